// ===== hw/rtl/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants of the stepper step pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

  localparam int unsigned SpgMinPeriod = 10;
  localparam int unsigned SpgMaxPeriod = 32767;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned TickW   = PeriodW + 1;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [PeriodW-1:0] PeriodRst = 16'd1000;

  typedef enum logic [1:0] {
    REG_STEP_PERIOD = 2'd0,
    REG_DIRECTION   = 2'd1,
    REG_LIMIT_CHECK = 2'd2
  } spg_reg_e;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } spg_req_e;

  typedef enum logic {
    DIR_UP   = 1'b0,
    DIR_DOWN = 1'b1
  } spg_dir_e;

  typedef struct packed {
    logic               req_type;
    logic [CountW-1:0]  step_count;
    logic [1:0]         limit_switches;
  } spg_in_t;

  typedef struct packed {
    logic                     step_level;
    logic                     step_edge;
    logic                     running;
    logic                     done_res;
    logic signed [CountW-1:0] position;
    logic [CountW-1:0]        steps_left;
  } spg_out_t;

  typedef struct packed {
    logic [PeriodW-1:0] step_period;
    logic               direction;
    logic               limit_check;
  } spg_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spg_regs.sv =====
// ----------------------------------------------------------------------------
// spg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [spg_pkg::AddrW-1:0] paddr,
  input  wire logic [spg_pkg::DataW-1:0] pwdata,
  output logic      [spg_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output spg_pkg::spg_cfg_t              cfg
);
  import spg_pkg::*;

  logic [PeriodW-1:0] period_r;
  logic               dir_r;
  logic               lim_r;
  logic               wr_en;
  spg_reg_e           sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = spg_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PeriodRst;
      dir_r    <= 1'b0;
      lim_r    <= 1'b0;
    end else if (wr_en) begin
      unique case (sel)
        REG_STEP_PERIOD: period_r <= pwdata[PeriodW-1:0];
        REG_DIRECTION:   dir_r    <= pwdata[0];
        REG_LIMIT_CHECK: lim_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_STEP_PERIOD: prdata = DataW'(period_r);
      REG_DIRECTION:   prdata = DataW'(dir_r);
      REG_LIMIT_CHECK: prdata = DataW'(lim_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.step_period = period_r;
  assign cfg.direction   = dir_r;
  assign cfg.limit_check = lim_r;

endmodule

`default_nettype wire

// ===== hw/rtl/spg_core.sv =====
// ----------------------------------------------------------------------------
// spg_core
// Step timer, step count, position and done state with their next-state update.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_core #(
  parameter int unsigned MIN_PERIOD = spg_pkg::SpgMinPeriod,
  parameter int unsigned MAX_PERIOD = spg_pkg::SpgMaxPeriod
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  spg_pkg::spg_in_t        item,
  input  spg_pkg::spg_cfg_t       cfg,
  output spg_pkg::spg_out_t       res
);
  import spg_pkg::*;

  localparam logic [PeriodW-1:0] MinP = PeriodW'(MIN_PERIOD);
  localparam logic [PeriodW-1:0] MaxP = PeriodW'(MAX_PERIOD);

  logic [TickW-1:0]         cnt_r, cnt_nxt, cnt_adv;
  logic [CountW-1:0]        rem_r, rem_nxt, rem_chk;
  logic                     high_r, high_nxt;
  logic                     on_r, on_nxt;
  logic signed [CountW-1:0] pos_r, pos_nxt;
  logic                     done_r, done_nxt;
  logic                     edge_nxt;
  logic [PeriodW-1:0]       period;
  logic                     hit;

  always_comb begin
    if (cfg.step_period > MaxP) begin
      period = MaxP;
    end else if (cfg.step_period < MinP) begin
      period = MinP;
    end else begin
      period = cfg.step_period;
    end
  end

  assign cnt_adv = (cnt_r >= {period, 1'b0}) ? '0 : cnt_r + TickW'(1);
  assign hit     = cfg.limit_check &&
                   ((cfg.direction == DIR_UP) ? item.limit_switches[1]
                                              : item.limit_switches[0]);
  assign rem_chk = hit ? '0 : rem_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    high_nxt = high_r;
    on_nxt   = on_r;
    pos_nxt  = pos_r;
    done_nxt = done_r;
    edge_nxt = 1'b0;
    if (item.req_type == REQ_START) begin
      rem_nxt  = item.step_count;
      on_nxt   = 1'b1;
      done_nxt = 1'b0;
    end else if (on_r) begin
      cnt_nxt = cnt_adv;
      if (cnt_adv == {1'b0, period}) begin
        if (high_r) begin
          high_nxt = 1'b0;
        end else if (rem_chk != '0) begin
          edge_nxt = 1'b1;
          rem_nxt  = rem_chk - CountW'(1);
          pos_nxt  = (cfg.direction == DIR_UP) ? pos_r + 32'sd1 : pos_r - 32'sd1;
          if (rem_chk == CountW'(1)) begin
            high_nxt = 1'b0;
            on_nxt   = 1'b0;
            done_nxt = 1'b1;
          end else begin
            high_nxt = 1'b1;
          end
        end else begin
          rem_nxt = rem_chk;
          on_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rem_r  <= '0;
      high_r <= 1'b0;
      on_r   <= 1'b0;
      pos_r  <= '0;
      done_r <= 1'b0;
    end else if (fire) begin
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      high_r <= high_nxt;
      on_r   <= on_nxt;
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  assign res.step_level = high_nxt;
  assign res.step_edge  = edge_nxt;
  assign res.running    = on_nxt;
  assign res.done_res   = done_nxt;
  assign res.position   = pos_nxt;
  assign res.steps_left = rem_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_pulse_generator_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_pulse_generator_unit
// Counted burst of stepper step pulses driven by timer tick and start beats.
// ----------------------------------------------------------------------------
// One beat is taken every clock cycle while in_stall is low and each beat
// yields one result beat: the input register holds the beat, the step timer
// and count update from it, and the result register presents the outcome.
// Throughput is one beat per cycle as long as out_stall stays low; a stalled
// result holds the input register and raises in_stall. Registers are to be
// written only while no beat is in flight; the block itself does not enforce it.
`default_nettype none

module stepper_pulse_generator_unit #(
  parameter int unsigned MIN_PERIOD = spg_pkg::SpgMinPeriod,
  parameter int unsigned MAX_PERIOD = spg_pkg::SpgMaxPeriod
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  spg_pkg::spg_in_t               in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output spg_pkg::spg_out_t              out_data,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [spg_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [spg_pkg::DataW-1:0] cfg_pwdata,
  output logic      [spg_pkg::DataW-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import spg_pkg::*;

  spg_cfg_t cfg;
  spg_in_t  in_data_r;
  logic     in_vld_r;
  spg_out_t res;
  spg_out_t out_data_r;
  logic     out_vld_r;
  logic     adv;

  spg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  spg_core #(
    .MIN_PERIOD (MIN_PERIOD),
    .MAX_PERIOD (MAX_PERIOD)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/spg_checker.sv =====
// ----------------------------------------------------------------------------
// spg_checker
// Port-level checks of the step pulse generator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input spg_pkg::spg_out_t      out_data
);
  import spg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_level_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_level |-> out_data.running)
    else $error("step level high with timer stopped");

  a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.running)
    else $error("done set while timer running");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_edge |->
      (out_data.running && out_data.steps_left != '0 && out_data.step_level) ||
      (!out_data.running && out_data.done_res && out_data.steps_left == '0 &&
       !out_data.step_level))
    else $error("step issued with inconsistent count or level");

endmodule

bind stepper_pulse_generator_unit spg_checker u_spg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
